// ===== design/quaternion_arithmetic_unit_macros.svh =====
// assertion macros for the quaternion arithmetic unit
// included by modules that carry concurrent checks; depends on nothing
`ifndef QUATERNION_ARITHMETIC_UNIT_MACROS_SVH
`define QUATERNION_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication
`define QAU_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define QAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/qau_pkg.sv =====
// shared types, opcodes and helpers of the quaternion arithmetic unit
// no dependencies
package qau_pkg;

   localparam int QAU_FRAC_DEF = 16;
   // divider widths for the default fraction width
   localparam int QAU_DW_DEF   = 49;
   localparam int QAU_NW_DEF   = 50;
   // quotient bits produced by the divider
   localparam int QAU_QW       = 33;

   typedef enum logic [3:0] {
      QAU_OP_ADD       = 4'd0,
      QAU_OP_SUB       = 4'd1,
      QAU_OP_MUL       = 4'd2,
      QAU_OP_SCALE     = 4'd3,
      QAU_OP_DIV       = 4'd4,
      QAU_OP_EQ        = 4'd5,
      QAU_OP_NE        = 4'd6,
      QAU_OP_NORM      = 4'd7,
      QAU_OP_NORMALIZE = 4'd8,
      QAU_OP_CONJ      = 4'd9,
      QAU_OP_INV       = 4'd10
   } qau_op_type;

   typedef struct packed {
      qau_op_type       op;
      logic [3:0][31:0] l;
      logic [31:0]      k;
      logic [3:0][31:0] res;
      logic             sat;
      logic             cmp;
      logic             zdiv;
      logic             nzero;
      logic             big;
      logic [31:0]      normv;
      logic [3:0]       neg;
   } qau_side_type;

   localparam int QAU_SIDE_W = $bits(qau_side_type);

   // clamp to signed 32 bits, msb of the result flags a clamp
   function automatic logic [32:0] qau_sat32(input logic signed [65:0] v);
      logic [32:0] r;
      if (v > 66'sd2147483647) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -66'sd2147483648) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

// ===== design/qau_sqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on qau_pkg
module qau_sqrt
   import qau_pkg::*;
#(
   parameter int TW = QAU_SIDE_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [63:0]   radicand,
   input  logic [TW-1:0] in_tag,
   output logic          out_valid,
   output logic [31:0]   root,
   output logic [33:0]   rem,
   output logic [TW-1:0] out_tag
);

   localparam int NST = 32;

   logic [NST-1:0] vld_ff;
   logic [33:0]    rem_ff  [NST];
   logic [31:0]    root_ff [NST];
   logic [63:0]    rad_ff  [NST];
   logic [TW-1:0]  tag_ff  [NST];

   for (genvar s = 0; s < NST; s++) begin : g_st
      logic [33:0]   rem_p;
      logic [31:0]   root_p;
      logic [63:0]   rad_p;
      logic          v_p;
      logic [TW-1:0] tag_p;
      logic [35:0]   rem_sh;
      logic [35:0]   trial;
      logic          ge;
      logic [33:0]   rem_in;

      if (s == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = radicand;
         assign v_p    = in_valid;
         assign tag_p  = in_tag;
      end else begin : g_next
         assign rem_p  = rem_ff[s-1];
         assign root_p = root_ff[s-1];
         assign rad_p  = rad_ff[s-1];
         assign v_p    = vld_ff[s-1];
         assign tag_p  = tag_ff[s-1];
      end

      // bring down two radicand bits, try 4*root+1
      assign rem_sh = {rem_p, rad_p[63:62]};
      assign trial  = {2'b00, root_p, 2'b01};
      assign ge     = rem_sh >= trial;
      assign rem_in = ge ? 34'(rem_sh - trial) : 34'(rem_sh);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= {root_p[30:0], ge};
            rad_ff[s]  <= {rad_p[61:0], 2'b00};
            tag_ff[s]  <= tag_p;
         end
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign root      = root_ff[NST-1];
   assign rem       = rem_ff[NST-1];
   assign out_tag   = tag_ff[NST-1];

endmodule

// ===== design/qau_div.sv =====
// pipelined restoring divider, four lanes sharing one divisor, one quotient bit per stage
// depends on qau_pkg
module qau_div
   import qau_pkg::*;
#(
   parameter int DW = QAU_DW_DEF,
   parameter int NW = QAU_NW_DEF,
   parameter int TW = QAU_SIDE_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [3:0][NW-1:0]    num,
   input  logic [DW-1:0]         dmag,
   input  logic [TW-1:0]         in_tag,
   output logic                  out_valid,
   output logic [3:0][QAU_QW-1:0] quot,
   output logic [3:0]            over,
   output logic [TW-1:0]         out_tag
);

   localparam int QW  = QAU_QW;
   localparam int NST = QW + 1;

   logic [NST-1:0]         vld_ff;
   logic [3:0][DW-1:0]     r_ff   [NST];
   logic [3:0][QW-1:0]     q_ff   [NST];
   logic [3:0][QW-1:0]     lo_ff  [NST];
   logic [3:0]             ov_ff  [NST];
   logic [DW-1:0]          dm_ff  [NST];
   logic [TW-1:0]          tag_ff [NST];

   for (genvar t = 0; t < NST; t++) begin : g_st
      logic [3:0][DW-1:0] r_in;
      logic [3:0][QW-1:0] q_in;
      logic [3:0][QW-1:0] lo_in;
      logic [3:0]         ov_in;
      logic [DW-1:0]      dm_in;
      logic               v_in;
      logic [TW-1:0]      tag_in;

      if (t == 0) begin : g_load
         // quotient of 2^QW or more saturates anyway, flag it up front
         always_comb begin
            for (int ln = 0; ln < 4; ln++) begin
               r_in[ln]  = DW'(num[ln][NW-1:QW]);
               ov_in[ln] = r_in[ln] >= dmag;
               lo_in[ln] = num[ln][QW-1:0];
               q_in[ln]  = '0;
            end
         end
         assign dm_in  = dmag;
         assign v_in   = in_valid;
         assign tag_in = in_tag;
      end else begin : g_step
         localparam int J = QW - t;
         logic [3:0][DW:0] r_sh;
         logic [3:0]       ge;

         always_comb begin
            for (int ln = 0; ln < 4; ln++) begin
               r_sh[ln]  = {r_ff[t-1][ln], lo_ff[t-1][ln][J]};
               ge[ln]    = r_sh[ln] >= {1'b0, dm_ff[t-1]};
               r_in[ln]  = ge[ln] ? DW'(r_sh[ln] - {1'b0, dm_ff[t-1]}) : DW'(r_sh[ln]);
               q_in[ln]    = q_ff[t-1][ln];
               q_in[ln][J] = ge[ln];
            end
         end
         assign lo_in  = lo_ff[t-1];
         assign ov_in  = ov_ff[t-1];
         assign dm_in  = dm_ff[t-1];
         assign v_in   = vld_ff[t-1];
         assign tag_in = tag_ff[t-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[t] <= 1'b0;
         end else if (en) begin
            vld_ff[t] <= v_in;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[t]   <= r_in;
            q_ff[t]   <= q_in;
            lo_ff[t]  <= lo_in;
            ov_ff[t]  <= ov_in;
            dm_ff[t]  <= dm_in;
            tag_ff[t] <= tag_in;
         end
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign quot      = q_ff[NST-1];
   assign over      = ov_ff[NST-1];
   assign out_tag   = tag_ff[NST-1];

endmodule

// ===== design/quaternion_arithmetic_unit.sv =====
// Quaternion ALU on signed fixed-point components.
// Input channel req_*: one word per operation, opcode in req_tuser, two quaternions and
// a scalar in req_tdata. Result channel rsp_*: one word per accepted request, in order.
// csr_*: write of the equality tolerance (reset value 66), take it while the unit is idle.
// Every opcode runs the same fixed pipeline: input register, product array, product sum,
// rounding, a 32-stage square root, norm squaring and divisor setup, a 34-stage four-lane
// divider and the output register. The unit takes one request every cycle while req_tready
// is high; the root and divider chains resolve one bit per stage.
// A stalled receiver is absorbed by a skid word behind the output register; when that skid
// word fills, the whole pipeline holds and req_tready drops, so nothing is lost or repeated.
// Reset empties the pipeline and both output words and restores the tolerance.
// Results are rounded to nearest and clamped to 32 bits; zero divisors give zero results and
// raise zero_divisor, except that normalize of a zero quaternion hands the input back.
// depends on qau_pkg, qau_sqrt, qau_div and quaternion_arithmetic_unit_macros.svh
`include "quaternion_arithmetic_unit_macros.svh"

module quaternion_arithmetic_unit
   import qau_pkg::*;
#(
   parameter int FRAC_BITS = QAU_FRAC_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // left w,x,y,z, right w,x,y,z, scale_factor (32 bits each, lowest first)
   input  logic [287:0] req_tdata,
   // req_type
   input  logic [3:0]   req_tuser,
   input  logic         req_tvalid,
   output logic         req_tready,
   // result w,x,y,z, norm_value, compare_true, zero_divisor, saturated, 5 zero bits
   output logic [167:0] rsp_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [15:0]  csr_data,
   input  logic         csr_valid,
   output logic         csr_ready
);

   localparam int DW = (65 - FRAC_BITS > 33) ? 65 - FRAC_BITS : 33;
   localparam int NW = ((32 + FRAC_BITS > 65 - FRAC_BITS) ? 32 + FRAC_BITS : 65 - FRAC_BITS) + 1;
   localparam logic signed [65:0] RND_HALF = 66'sd1 <<< (FRAC_BITS - 1);
   localparam logic [65:0]        SQ_HALF  = 66'd1 << (FRAC_BITS - 1);

   typedef struct packed {
      logic [3:0][31:0] res;
      logic [31:0]      normv;
      logic             cmp;
      logic             zdiv;
      logic             sat;
   } rsp_type;

   logic        en;
   logic [15:0] tol_ff;

   // ---------------- configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= 16'd66;
      end else if (csr_valid) begin
         tol_ff <= csr_data;
      end
   end

   // ---------------- input register
   logic               v0_ff;
   qau_op_type         op0_ff;
   logic signed [31:0] l0_ff [4];
   logic signed [31:0] r0_ff [4];
   logic signed [31:0] k0_ff;

   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op0_ff <= qau_op_type'(req_tuser);
         for (int i = 0; i < 4; i++) begin
            l0_ff[i] <= req_tdata[32*i +: 32];
            r0_ff[i] <= req_tdata[128 + 32*i +: 32];
         end
         k0_ff <= req_tdata[287:256];
      end
   end

   // ---------------- stage 1: product array and simple ops
   logic signed [31:0] ma_in [4][4];
   logic signed [31:0] mb_in [4][4];
   logic [3:0][3:0]    ng_in;
   logic [32:0]        add_s [4];
   logic [32:0]        sub_s [4];
   logic [32:0]        neg_s [4];
   logic signed [32:0] diff  [4];
   logic [32:0]        absd  [4];
   logic               eq_all;
   qau_side_type       side1_in;

   logic               v1_ff;
   qau_side_type       side1_ff;
   logic signed [63:0] p1_ff [4][4];
   logic [3:0][3:0]    ng1_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            ma_in[i][j] = '0;
            mb_in[i][j] = '0;
         end
      end
      ng_in = '0;
      case (op0_ff)
         QAU_OP_MUL: begin
            // row i builds component i of the hamilton product
            ma_in[0][0] = l0_ff[0]; mb_in[0][0] = r0_ff[0];
            ma_in[0][1] = l0_ff[1]; mb_in[0][1] = r0_ff[1];
            ma_in[0][2] = l0_ff[2]; mb_in[0][2] = r0_ff[2];
            ma_in[0][3] = l0_ff[3]; mb_in[0][3] = r0_ff[3];
            ng_in[0]    = 4'b1110;
            ma_in[1][0] = l0_ff[1]; mb_in[1][0] = r0_ff[0];
            ma_in[1][1] = r0_ff[1]; mb_in[1][1] = l0_ff[0];
            ma_in[1][2] = l0_ff[2]; mb_in[1][2] = r0_ff[3];
            ma_in[1][3] = l0_ff[3]; mb_in[1][3] = r0_ff[2];
            ng_in[1]    = 4'b1000;
            ma_in[2][0] = l0_ff[2]; mb_in[2][0] = r0_ff[0];
            ma_in[2][1] = r0_ff[2]; mb_in[2][1] = l0_ff[0];
            ma_in[2][2] = l0_ff[3]; mb_in[2][2] = r0_ff[1];
            ma_in[2][3] = l0_ff[1]; mb_in[2][3] = r0_ff[3];
            ng_in[2]    = 4'b1000;
            ma_in[3][0] = l0_ff[3]; mb_in[3][0] = r0_ff[0];
            ma_in[3][1] = r0_ff[3]; mb_in[3][1] = l0_ff[0];
            ma_in[3][2] = l0_ff[1]; mb_in[3][2] = r0_ff[2];
            ma_in[3][3] = l0_ff[2]; mb_in[3][3] = r0_ff[1];
            ng_in[3]    = 4'b1000;
         end
         QAU_OP_SCALE: begin
            for (int i = 0; i < 4; i++) begin
               ma_in[i][0] = l0_ff[i];
               mb_in[i][0] = k0_ff;
            end
         end
         QAU_OP_NORM, QAU_OP_NORMALIZE, QAU_OP_INV: begin
            // row 0 sums the squares
            for (int j = 0; j < 4; j++) begin
               ma_in[0][j] = l0_ff[j];
               mb_in[0][j] = l0_ff[j];
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      side1_in = '0;
      eq_all   = 1'b1;
      for (int i = 0; i < 4; i++) begin
         add_s[i] = qau_sat32(66'(33'(l0_ff[i]) + 33'(r0_ff[i])));
         sub_s[i] = qau_sat32(66'(33'(l0_ff[i]) - 33'(r0_ff[i])));
         neg_s[i] = qau_sat32(-66'(l0_ff[i]));
         diff[i]  = 33'(l0_ff[i]) - 33'(r0_ff[i]);
         absd[i]  = diff[i][32] ? 33'(-diff[i]) : 33'(diff[i]);
         if (absd[i] > 33'(tol_ff)) begin
            eq_all = 1'b0;
         end
         side1_in.l[i] = l0_ff[i];
      end
      side1_in.op = op0_ff;
      side1_in.k  = k0_ff;
      case (op0_ff)
         QAU_OP_ADD: begin
            for (int i = 0; i < 4; i++) begin
               side1_in.res[i] = add_s[i][31:0];
               side1_in.sat    = side1_in.sat | add_s[i][32];
            end
         end
         QAU_OP_SUB: begin
            for (int i = 0; i < 4; i++) begin
               side1_in.res[i] = sub_s[i][31:0];
               side1_in.sat    = side1_in.sat | sub_s[i][32];
            end
         end
         QAU_OP_CONJ: begin
            side1_in.res[0] = l0_ff[0];
            for (int i = 1; i < 4; i++) begin
               side1_in.res[i] = neg_s[i][31:0];
               side1_in.sat    = side1_in.sat | neg_s[i][32];
            end
         end
         QAU_OP_EQ: side1_in.cmp = eq_all;
         QAU_OP_NE: side1_in.cmp = !eq_all;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= v0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side1_ff <= side1_in;
         ng1_ff   <= ng_in;
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               p1_ff[i][j] <= ma_in[i][j] * mb_in[i][j];
            end
         end
      end
   end

   // ---------------- stage 2: exact sums of products
   logic signed [65:0] sum2_in [4];
   logic               v2_ff;
   qau_side_type       side2_ff;
   logic signed [65:0] sum2_ff [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         sum2_in[i] = '0;
         for (int j = 0; j < 4; j++) begin
            sum2_in[i] = sum2_in[i] + (ng1_ff[i][j] ? -66'(p1_ff[i][j]) : 66'(p1_ff[i][j]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side2_ff <= side1_ff;
         sum2_ff  <= sum2_in;
      end
   end

   // ---------------- stage 3: round, clamp, merge
   logic signed [65:0] rnd   [4];
   logic [32:0]        rnd_s [4];
   qau_side_type       side3_in;
   logic               v3_ff;
   qau_side_type       side3_ff;
   logic [63:0]        rad3_ff;

   always_comb begin
      side3_in     = side2_ff;
      side3_in.big = sum2_ff[0][64];
      for (int i = 0; i < 4; i++) begin
         rnd[i]   = (sum2_ff[i] + RND_HALF) >>> FRAC_BITS;
         rnd_s[i] = qau_sat32(rnd[i]);
      end
      case (side2_ff.op)
         QAU_OP_ADD, QAU_OP_SUB, QAU_OP_CONJ: begin
         end
         QAU_OP_MUL, QAU_OP_SCALE: begin
            for (int i = 0; i < 4; i++) begin
               side3_in.res[i] = rnd_s[i][31:0];
               side3_in.sat    = side3_in.sat | rnd_s[i][32];
            end
         end
         default: begin
            side3_in.res = '0;
            side3_in.sat = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side3_ff <= side3_in;
         rad3_ff  <= sum2_ff[0][63:0];
      end
   end

   // ---------------- square root
   logic                  sq_valid;
   logic [31:0]           sq_root;
   logic [33:0]           sq_rem;
   logic [QAU_SIDE_W-1:0] sq_tag;

   qau_sqrt #(
      .TW (QAU_SIDE_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v3_ff),
      .radicand  (rad3_ff),
      .in_tag    (side3_ff),
      .out_valid (sq_valid),
      .root      (sq_root),
      .rem       (sq_rem),
      .out_tag   (sq_tag)
   );

   // ---------------- stage 4: rounded norm
   qau_side_type sd4;
   qau_side_type side4_in;
   logic [32:0]  n4_in;
   logic         v4_ff;
   qau_side_type side4_ff;
   logic [32:0]  n4_ff;

   always_comb begin
      sd4      = qau_side_type'(sq_tag);
      side4_in = sd4;
      // a sum of exactly 2^64 does not fit the root pipeline
      n4_in = sd4.big ? {1'b1, 32'h0} : 33'(sq_root) + 33'(sq_rem > 34'(sq_root));
      if (sd4.op == QAU_OP_NORM) begin
         side4_in.normv = n4_in[32] ? 32'hFFFF_FFFF : n4_in[31:0];
         side4_in.sat   = n4_in[32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side4_ff <= side4_in;
         n4_ff    <= n4_in;
      end
   end

   // ---------------- stage 5: norm squared
   logic [65:0]  nsq5_in;
   logic         v5_ff;
   qau_side_type side5_ff;
   logic [32:0]  n5_ff;
   logic [65:0]  nsq5_ff;

   assign nsq5_in = n4_ff * n4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side5_ff <= side4_ff;
         n5_ff    <= n4_ff;
         nsq5_ff  <= nsq5_in;
      end
   end

   // ---------------- stage 6: rounded squared norm
   logic [65:0]   d6_full;
   logic          v6_ff;
   qau_side_type  side6_ff;
   logic [32:0]   n6_ff;
   logic [DW-1:0] d6_ff;

   assign d6_full = (nsq5_ff + SQ_HALF) >> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side6_ff <= side5_ff;
         n6_ff    <= n5_ff;
         d6_ff    <= d6_full[DW-1:0];
      end
   end

   // ---------------- stage 7: divisor and dividends
   qau_side_type       side7_in;
   logic [DW-1:0]      dm7_in;
   logic [3:0][NW-1:0] num7_in;
   logic [31:0]        kmag;
   logic [31:0]        lmag [4];
   logic               v7_ff;
   qau_side_type       side7_ff;
   logic [DW-1:0]      dm7_ff;
   logic [3:0][NW-1:0] num7_ff;

   always_comb begin
      side7_in = side6_ff;
      dm7_in   = '0;
      kmag     = side6_ff.k[31] ? 32'(-side6_ff.k) : side6_ff.k;
      case (side6_ff.op)
         QAU_OP_DIV: begin
            dm7_in        = DW'(kmag);
            side7_in.zdiv = side6_ff.k == 32'h0;
         end
         QAU_OP_NORMALIZE: begin
            dm7_in         = DW'(n6_ff);
            side7_in.nzero = n6_ff == 33'h0;
         end
         QAU_OP_INV: begin
            dm7_in        = d6_ff;
            side7_in.zdiv = d6_ff == '0;
         end
         default: begin
         end
      endcase
      for (int ln = 0; ln < 4; ln++) begin
         lmag[ln] = side6_ff.l[ln][31] ? 32'(-side6_ff.l[ln]) : side6_ff.l[ln];
         case (side6_ff.op)
            QAU_OP_DIV: side7_in.neg[ln] = side6_ff.l[ln][31] ^ side6_ff.k[31];
            // inverse divides the conjugate
            QAU_OP_INV: side7_in.neg[ln] = (ln == 0) ? side6_ff.l[ln][31] :
                                           (!side6_ff.l[ln][31] && side6_ff.l[ln] != 32'h0);
            default:    side7_in.neg[ln] = side6_ff.l[ln][31];
         endcase
         num7_in[ln] = (NW'(lmag[ln]) << FRAC_BITS) + NW'(dm7_in >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (en) begin
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side7_ff <= side7_in;
         dm7_ff   <= dm7_in;
         num7_ff  <= num7_in;
      end
   end

   // ---------------- divider
   logic                     dv_valid;
   logic [3:0][QAU_QW-1:0]   dv_quot;
   logic [3:0]               dv_over;
   logic [QAU_SIDE_W-1:0]    dv_tag;

   qau_div #(
      .DW (DW),
      .NW (NW),
      .TW (QAU_SIDE_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v7_ff),
      .num       (num7_ff),
      .dmag      (dm7_ff),
      .in_tag    (side7_ff),
      .out_valid (dv_valid),
      .quot      (dv_quot),
      .over      (dv_over),
      .out_tag   (dv_tag)
   );

   // ---------------- final sign, clamp and result select
   qau_side_type sdf;
   rsp_type      fin_in;

   always_comb begin
      sdf          = qau_side_type'(dv_tag);
      fin_in.res   = sdf.res;
      fin_in.normv = sdf.normv;
      fin_in.cmp   = sdf.cmp;
      fin_in.zdiv  = sdf.zdiv;
      fin_in.sat   = sdf.sat;
      if (sdf.op inside {QAU_OP_DIV, QAU_OP_NORMALIZE, QAU_OP_INV}) begin
         if (sdf.zdiv) begin
            fin_in.res = '0;
         end else if (sdf.nzero) begin
            // zero norm hands the input back
            fin_in.res = sdf.l;
         end else begin
            for (int ln = 0; ln < 4; ln++) begin
               if (sdf.neg[ln]) begin
                  if (dv_over[ln] || dv_quot[ln] > 33'h0_8000_0000) begin
                     fin_in.res[ln] = 32'h8000_0000;
                     fin_in.sat     = 1'b1;
                  end else begin
                     fin_in.res[ln] = 32'(-dv_quot[ln][31:0]);
                  end
               end else begin
                  if (dv_over[ln] || dv_quot[ln] > 33'h0_7FFF_FFFF) begin
                     fin_in.res[ln] = 32'h7FFF_FFFF;
                     fin_in.sat     = 1'b1;
                  end else begin
                     fin_in.res[ln] = dv_quot[ln][31:0];
                  end
               end
            end
         end
      end
   end

   // ---------------- output word and skid word
   logic    out_valid_ff;
   logic    skid_valid_ff;
   rsp_type out_ff;
   rsp_type skid_ff;

   // the pipeline holds only while the skid word is occupied
   assign en = !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_tready) begin
            if (skid_valid_ff) begin
               skid_valid_ff <= 1'b0;
            end else begin
               out_valid_ff <= dv_valid;
            end
         end else if (!out_valid_ff) begin
            out_valid_ff <= dv_valid;
         end else if (en && dv_valid) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid_ff && rsp_tready) begin
         out_ff <= skid_valid_ff ? skid_ff : fin_in;
      end else if (!out_valid_ff) begin
         out_ff <= fin_in;
      end
      if (en) begin
         skid_ff <= fin_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_ff.sat, out_ff.zdiv, out_ff.cmp, out_ff.normv,
                        out_ff.res[3], out_ff.res[2], out_ff.res[1], out_ff.res[0]};

   // ---------------- checks
   `QAU_ASSERT_IMPLY(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff,
                     "skid word held without an output word")
   `QAU_ASSERT_NEXT(a_skid_kept, clock, reset, skid_valid_ff && !rsp_tready, skid_valid_ff,
                    "skid word dropped while the receiver stalls")
   `QAU_ASSERT_IMPLY(a_zdiv_zero, clock, reset, out_valid_ff && out_ff.zdiv,
                     out_ff.res == '0 && !out_ff.sat, "zero divisor with a nonzero result")
   `QAU_ASSERT_IMPLY(a_cmp_alone, clock, reset, out_valid_ff && out_ff.cmp,
                     out_ff.res == '0 && out_ff.normv == 32'h0 && !out_ff.zdiv,
                     "compare result mixed with arithmetic output")

endmodule

// ===== test/tb_top.sv =====
// self-checking bench for the quaternion arithmetic unit: drives request words,
// predicts each result from its own fixed-point model and checks the responses
// depends on qau_pkg and the quaternion_arithmetic_unit rtl
`timescale 1ns / 1ps

module tb_top;
   import qau_pkg::*;

   localparam int FRAC = 16;
   localparam int LATENCY = 74;
   localparam int LIMIT_CYCLES = 600000;
   localparam logic [3:0] OP_FIRST_UNUSED = 4'd11;
   localparam logic [3:0] OP_LAST_CODE = 4'd15;
   localparam int RESET_TOL = 66;

   typedef struct {
      logic [3:0] op;
      int         lq[4];
      int         rq[4];
      int         k;
   } quat_req_type;

   typedef struct {
      int          res[4];
      int unsigned normv;
      bit          cmp;
      bit          zdiv;
      bit          sat;
   } quat_rsp_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [287:0] req_tdata = '0;
   logic [3:0]   req_tuser = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [167:0] rsp_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [15:0]  csr_data = '0;
   logic         csr_valid = 1'b0;
   logic         csr_ready;

   quat_req_type pending_words[$];
   quat_rsp_type expected_rsp[$];
   quat_req_type cur_word;
   int unsigned tolerance = RESET_TOL;
   int  errors = 0;
   int  words_sent = 0;
   int  words_checked = 0;
   int  op_hits[16];
   int  send_gap = 0;
   int  rsp_gap = 0;
   int  long_hold_left = 0;
   bit  long_hold_req = 1'b0;
   bit  long_hold_done = 1'b0;
   bit  quiet = 1'b0;
   longint unsigned cycles = 0;

   quaternion_arithmetic_unit u_top (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_data(csr_data), .csr_valid(csr_valid), .csr_ready(csr_ready)
   );

   always #5 clock = ~clock;

   // ---------------- fixed-point helpers ----------------

   function automatic longint clamp32(longint v, inout bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // round to nearest, ties toward plus infinity, then clamp
   function automatic longint round_frac(logic signed [127:0] v, inout bit sat);
      logic signed [127:0] t;
      t = (v + (128'sd1 <<< (FRAC - 1))) >>> FRAC;
      if (t > 128'sd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      if (t < -128'sd2147483648) begin
         sat = 1'b1;
         return -64'sd2147483648;
      end
      return longint'(t);
   endfunction

   // signed divide, magnitude rounded half away from zero
   function automatic longint div_frac(longint num, bit den_neg, logic [63:0] dmag,
                                       inout bit sat);
      logic [63:0] mag;
      logic [63:0] q;
      bit neg;
      mag = (num < 0) ? 64'(-num) : 64'(num);
      q = ((mag << FRAC) + dmag / 2) / dmag;
      neg = (num < 0) != den_neg;
      if (neg) begin
         if (q > 64'd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
         end
         return -longint'(q);
      end
      if (q > 64'd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      return longint'(q);
   endfunction

   // rounded euclidean length, up to 2^32
   function automatic logic [63:0] length_of(int c[4]);
      logic [127:0] rem;
      logic [127:0] root;
      logic [127:0] bitv;
      longint sq;
      rem = '0;
      root = '0;
      for (int i = 0; i < 4; i++) begin
         sq = longint'(c[i]) * longint'(c[i]);
         rem = rem + 128'(sq);
      end
      bitv = 128'd1 << 64;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      if (rem > root) root = root + 1;
      return root[63:0];
   endfunction

   function automatic logic signed [127:0] mul_wide(int a, int b);
      logic signed [127:0] t;
      t = longint'(a) * longint'(b);
      return t;
   endfunction

   function automatic quat_rsp_type predict_quat(quat_req_type w, int unsigned tol);
      quat_rsp_type o;
      bit sat;
      bit eq;
      longint d;
      logic [63:0] n;
      int l[4];
      int r[4];
      sat = 1'b0;
      eq = 1'b1;
      l = w.lq;
      r = w.rq;
      o.res = '{0, 0, 0, 0};
      o.normv = 0;
      o.cmp = 1'b0;
      o.zdiv = 1'b0;
      case (w.op)
         QAU_OP_ADD: begin
            for (int i = 0; i < 4; i++)
               o.res[i] = int'(clamp32(longint'(l[i]) + longint'(r[i]), sat));
         end
         QAU_OP_SUB: begin
            for (int i = 0; i < 4; i++)
               o.res[i] = int'(clamp32(longint'(l[i]) - longint'(r[i]), sat));
         end
         QAU_OP_MUL: begin
            o.res[0] = int'(round_frac(mul_wide(l[0], r[0]) - mul_wide(l[1], r[1])
                                     - mul_wide(l[2], r[2]) - mul_wide(l[3], r[3]), sat));
            o.res[1] = int'(round_frac(mul_wide(l[1], r[0]) + mul_wide(r[1], l[0])
                                     + mul_wide(l[2], r[3]) - mul_wide(l[3], r[2]), sat));
            o.res[2] = int'(round_frac(mul_wide(l[2], r[0]) + mul_wide(r[2], l[0])
                                     + mul_wide(l[3], r[1]) - mul_wide(l[1], r[3]), sat));
            o.res[3] = int'(round_frac(mul_wide(l[3], r[0]) + mul_wide(r[3], l[0])
                                     + mul_wide(l[1], r[2]) - mul_wide(l[2], r[1]), sat));
         end
         QAU_OP_SCALE: begin
            for (int i = 0; i < 4; i++)
               o.res[i] = int'(round_frac(mul_wide(l[i], w.k), sat));
         end
         QAU_OP_DIV: begin
            if (w.k == 0) begin
               o.zdiv = 1'b1;
            end else begin
               for (int i = 0; i < 4; i++)
                  o.res[i] = int'(div_frac(l[i], w.k < 0,
                                           (w.k < 0) ? 64'(-longint'(w.k)) : 64'(w.k),
                                           sat));
            end
         end
         QAU_OP_EQ, QAU_OP_NE: begin
            for (int i = 0; i < 4; i++) begin
               d = longint'(l[i]) - longint'(r[i]);
               if (d < 0) d = -d;
               if (d > longint'(tol)) eq = 1'b0;
            end
            o.cmp = (w.op == QAU_OP_EQ) ? eq : !eq;
         end
         QAU_OP_NORM: begin
            n = length_of(l);
            if (n > 64'hFFFF_FFFF) begin
               sat = 1'b1;
               n = 64'hFFFF_FFFF;
            end
            o.normv = n[31:0];
         end
         QAU_OP_NORMALIZE: begin
            n = length_of(l);
            for (int i = 0; i < 4; i++)
               o.res[i] = (n == 0) ? l[i] : int'(div_frac(l[i], 1'b0, n, sat));
         end
         QAU_OP_CONJ: begin
            o.res[0] = l[0];
            for (int i = 1; i < 4; i++) o.res[i] = int'(clamp32(-longint'(l[i]), sat));
         end
         QAU_OP_INV: begin
            n = length_of(l);
            // squared length in fixed point; the all-minimum case is 2^32 before squaring
            if (n == 64'h1_0000_0000) n = 64'd1 << (64 - FRAC);
            else n = (n * n + (64'd1 << (FRAC - 1))) >> FRAC;
            if (n == 0) begin
               o.zdiv = 1'b1;
            end else begin
               o.res[0] = int'(div_frac(l[0], 1'b0, n, sat));
               for (int i = 1; i < 4; i++)
                  o.res[i] = int'(div_frac(-longint'(l[i]), 1'b0, n, sat));
            end
         end
         default: ;
      endcase
      o.sat = sat;
      return o;
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic int pick_component();
      int v;
      case ($urandom_range(0, 6))
         0, 1: v = int'($urandom());
         2: v = int'($urandom_range(0, 2097152)) - 1048576;
         3: v = (int'($urandom_range(0, 8)) - 4) * 65536;
         4: begin
            case ($urandom_range(0, 5))
               0: v = 32'sh7FFF_FFFF;
               1: v = 32'sh8000_0000;
               2: v = 0;
               3: v = 1;
               4: v = -1;
               default: v = 65536;
            endcase
         end
         5: v = int'($urandom_range(0, 400)) - 200;
         default: v = int'($urandom()) >>> $urandom_range(0, 30);
      endcase
      return v;
   endfunction

   function automatic quat_req_type random_word();
      quat_req_type w;
      if ($urandom_range(0, 39) == 0)
         w.op = 4'($urandom_range(OP_FIRST_UNUSED, OP_LAST_CODE));
      else
         w.op = 4'($urandom_range(QAU_OP_ADD, QAU_OP_INV));
      for (int i = 0; i < 4; i++) begin
         w.lq[i] = pick_component();
         w.rq[i] = pick_component();
      end
      w.k = pick_component();
      // compare near the tolerance edge most of the time
      if ((w.op == QAU_OP_EQ || w.op == QAU_OP_NE) && $urandom_range(0, 3) != 0) begin
         for (int i = 0; i < 4; i++)
            w.rq[i] = w.lq[i] + int'($urandom_range(0, 2 * tolerance + 4))
                      - int'(tolerance) - 2;
      end
      if (w.op == QAU_OP_DIV && $urandom_range(0, 7) == 0) w.k = 0;
      // tiny and zero quaternions for normalize and inverse
      if ((w.op == QAU_OP_INV || w.op == QAU_OP_NORMALIZE) && $urandom_range(0, 4) == 0) begin
         for (int i = 0; i < 4; i++)
            w.lq[i] = ($urandom_range(0, 1) != 0) ? int'($urandom_range(0, 200)) - 100 : 0;
      end
      return w;
   endfunction

   function automatic quat_req_type make_word(logic [3:0] op, int a, int b, int k);
      quat_req_type w;
      w.op = op;
      w.lq = '{a, a, a, a};
      w.rq = '{b, b, b, b};
      w.k = k;
      return w;
   endfunction

   // ---------------- request driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsp.push_back(predict_quat(cur_word, tolerance));
            op_hits[cur_word.op]++;
            words_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               cur_word = pending_words.pop_front();
               req_tuser <= cur_word.op;
               req_tdata <= {cur_word.k, cur_word.rq[3], cur_word.rq[2], cur_word.rq[1],
                             cur_word.rq[0], cur_word.lq[3], cur_word.lq[2],
                             cur_word.lq[1], cur_word.lq[0]};
               req_tvalid <= 1'b1;
               if (!quiet && $urandom_range(0, 19) == 0) send_gap <= $urandom_range(1, 15);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------- response monitor ----------------

   always @(posedge clock) begin
      quat_rsp_type e;
      quat_rsp_type a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         for (int i = 0; i < 4; i++) a.res[i] = int'(rsp_tdata[32 * i +: 32]);
         a.normv = rsp_tdata[159:128];
         a.cmp = rsp_tdata[160];
         a.zdiv = rsp_tdata[161];
         a.sat = rsp_tdata[162];
         if (expected_rsp.size() == 0) begin
            $error("unexpected response word");
            errors++;
         end else begin
            e = expected_rsp.pop_front();
            words_checked++;
            for (int i = 0; i < 4; i++) begin
               if (a.res[i] !== e.res[i]) begin
                  $error("result[%0d] expected %0d actual %0d", i, e.res[i], a.res[i]);
                  errors++;
               end
            end
            if (a.normv !== e.normv) begin
               $error("norm_value expected %0d actual %0d", e.normv, a.normv);
               errors++;
            end
            if (a.cmp !== e.cmp) begin
               $error("compare_true expected %0d actual %0d", e.cmp, a.cmp);
               errors++;
            end
            if (a.zdiv !== e.zdiv) begin
               $error("zero_divisor expected %0d actual %0d", e.zdiv, a.zdiv);
               errors++;
            end
            if (a.sat !== e.sat) begin
               $error("saturated expected %0d actual %0d", e.sat, a.sat);
               errors++;
            end
         end
      end
   end

   // receiver backpressure, including one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_req && !long_hold_done) begin
         long_hold_done <= 1'b1;
         long_hold_left <= 300;
         rsp_tready <= 1'b0;
      end else if (long_hold_left > 0) begin
         long_hold_left <= long_hold_left - 1;
         rsp_tready <= (long_hold_left == 1);
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_tready <= (rsp_gap == 1);
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
         rsp_gap <= $urandom_range(1, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("quaternion_arithmetic_unit regression: fail");
         $finish;
      end
   end

   // ---------------- test sequence ----------------

   task automatic drain_all();
      while (pending_words.size() != 0 || req_tvalid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [15:0] v);
      @(posedge clock);
      csr_data <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tolerance = v;
   endtask

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++) pending_words.push_back(random_word());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed words at the reset tolerance
      pending_words.push_back(make_word(QAU_OP_ADD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0));
      pending_words.push_back(make_word(QAU_OP_SUB, 32'sh8000_0000, 1, 0));
      pending_words.push_back(make_word(QAU_OP_SUB, 0, 32'sh8000_0000, 0));
      pending_words.push_back(make_word(QAU_OP_MUL, 32'sh8000_0000, 32'sh8000_0000, 0));
      pending_words.push_back(make_word(QAU_OP_MUL, 65536, 98304, 0));
      pending_words.push_back(make_word(QAU_OP_SCALE, 32'sh7FFF_FFFF, 0, 32'sh8000_0000));
      pending_words.push_back(make_word(QAU_OP_SCALE, 3, 0, 32768));
      pending_words.push_back(make_word(QAU_OP_DIV, 65536, 0, 0));
      pending_words.push_back(make_word(QAU_OP_DIV, 32'sh8000_0000, 0, -1));
      pending_words.push_back(make_word(QAU_OP_DIV, 32'sh8000_0000, 0, 65536));
      pending_words.push_back(make_word(QAU_OP_EQ, 1000, 1066, 0));
      pending_words.push_back(make_word(QAU_OP_EQ, 1000, 1067, 0));
      pending_words.push_back(make_word(QAU_OP_NE, 32'sh8000_0000, 32'sh7FFF_FFFF, 0));
      pending_words.push_back(make_word(QAU_OP_NORM, 32'sh8000_0000, 0, 0));
      pending_words.push_back(make_word(QAU_OP_NORM, 32'sh7FFF_FFFF, 0, 0));
      pending_words.push_back(make_word(QAU_OP_NORMALIZE, 0, 0, 0));
      pending_words.push_back(make_word(QAU_OP_NORMALIZE, 32'sh8000_0000, 0, 0));
      pending_words.push_back(make_word(QAU_OP_CONJ, 32'sh8000_0000, 0, 0));
      pending_words.push_back(make_word(QAU_OP_INV, 0, 0, 0));
      pending_words.push_back(make_word(QAU_OP_INV, 5, 0, 0));
      pending_words.push_back(make_word(QAU_OP_INV, 32'sh8000_0000, 0, 0));
      pending_words.push_back(make_word(QAU_OP_INV, 32768, 0, 0));
      pending_words.push_back(make_word(OP_FIRST_UNUSED, -1, -1, -1));
      pending_words.push_back(make_word(OP_LAST_CODE, 32'sh7FFF_FFFF, -1, -1));
      drain_all();

      write_tolerance(16'd0);
      queue_random(300);
      drain_all();

      // the receiver stalls long enough for the pipeline and skid word to fill
      write_tolerance(16'hFFFF);
      long_hold_req = 1'b1;
      queue_random(300);
      drain_all();

      write_tolerance(16'($urandom_range(1, 65534)));
      queue_random(300);
      drain_all();

      // closing stretch without idling on either side
      write_tolerance(16'(RESET_TOL));
      quiet = 1'b1;
      queue_random(300);
      drain_all();

      if (expected_rsp.size() != 0) begin
         $error("%0d responses never arrived", expected_rsp.size());
         errors++;
      end
      $display("covered %0d requests, %0d responses checked, over five tolerance settings",
               words_sent, words_checked);
      $display("ops seen: add %0d sub %0d mul %0d scale %0d div %0d eq %0d ne %0d",
               op_hits[QAU_OP_ADD], op_hits[QAU_OP_SUB], op_hits[QAU_OP_MUL],
               op_hits[QAU_OP_SCALE], op_hits[QAU_OP_DIV], op_hits[QAU_OP_EQ],
               op_hits[QAU_OP_NE]);
      if (errors == 0) begin
         $display("quaternion_arithmetic_unit regression: pass");
      end else begin
         $display("quaternion_arithmetic_unit regression: fail");
      end
      $finish;
   end

endmodule
